// ===== rtl/text_buffer_prescan_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef TEXT_BUFFER_PRESCAN_DEFINES_SVH
`define TEXT_BUFFER_PRESCAN_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define TBP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("prescan invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define TBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prescan sequence violated");

`endif

// ===== rtl/tbp_pkg.sv =====
`timescale 1ns / 1ps

package tbp_pkg;

    localparam int INDEX_BITS = 32;
    localparam int PEEK_BYTES = 4;
    localparam int LEN_BITS   = 21;
    localparam int THR_BITS   = 20;
    localparam int OUT_BITS   = 32;

    localparam logic [THR_BITS-1:0] TEXT_THR_RESET = THR_BITS'(500000);
    localparam logic [THR_BITS-1:0] WIDE_THR_RESET = THR_BITS'(500004);

    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_FE  = 8'hFE;
    localparam logic [7:0] BYTE_FF  = 8'hFF;

    typedef logic [7:0]                t_byte;
    typedef t_byte [PEEK_BYTES-1:0]    t_peek_arr;
    typedef logic [INDEX_BITS-1:0]     t_pos;
    typedef logic [LEN_BITS-1:0]       t_len;
    typedef logic [THR_BITS-1:0]       t_thr;

    typedef enum logic [1:0] {
        CFG_CHARSET  = 2'd0,
        CFG_TEXT_THR = 2'd1,
        CFG_WIDE_THR = 2'd2
    } t_cfg_idx;

    // Outcome of the four-byte peek.
    typedef struct packed {
        logic guess16;
        logic guess32;
        logic eol_any;
    } t_peek_res;

    function automatic logic is_eol(input t_byte b);
        return (b == BYTE_LF) || (b == BYTE_CR);
    endfunction

endpackage

// ===== rtl/tbp_peek.sv =====
`timescale 1ns / 1ps

// Encoding guess and line-break check over the held head bytes.
module tbp_peek (
    input  tbp_pkg::t_peek_arr i_bytes,
    input  logic [2:0]         i_count,
    input  logic               i_null_seen,
    input  logic               i_charset_enforced,
    output tbp_pkg::t_peek_res o_res
);

    logic [tbp_pkg::PEEK_BYTES-1:0] nz;
    logic bom;
    logic p16;
    logic p32;

    always_comb begin
        for (int i = 0; i < tbp_pkg::PEEK_BYTES; i++) begin
            nz[i] = (i_bytes[i] != tbp_pkg::BYTE_NUL);
        end
        bom = ((i_bytes[0] == tbp_pkg::BYTE_FF) && (i_bytes[1] == tbp_pkg::BYTE_FE)) ||
              ((i_bytes[0] == tbp_pkg::BYTE_FE) && (i_bytes[1] == tbp_pkg::BYTE_FF));
        p16 = (nz == 4'b0101) || (nz == 4'b1010);
        p32 = (nz == 4'b0011) || (nz == 4'b1100);

        o_res = '0;
        if (!i_charset_enforced) begin
            // two-byte file with exactly one NUL
            if ((i_count == 3'd2) && (nz[0] != nz[1])) begin
                o_res.guess16 = 1'b1;
            end
            if ((i_count == 3'd4) && i_null_seen) begin
                if (bom || p16) begin
                    o_res.guess16 = 1'b1;
                end else if (p32) begin
                    o_res.guess32 = 1'b1;
                end
            end
        end

        for (int i = 0; i < tbp_pkg::PEEK_BYTES; i++) begin
            if ((3'(i) < i_count) && tbp_pkg::is_eol(i_bytes[i])) begin
                o_res.eol_any = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/text_buffer_prescan.sv =====
`timescale 1ns / 1ps

// Byte-stream prescan for a text buffer. Each input word is one file byte;
// the word flagged last closes the file and yields one summary word: NUL seen
// (up to the cutoff), UTF-16/UTF-32 guesses from the first four bytes, and
// whether some line ran past the length limit together with the number of
// bytes to keep. A byte is taken every cycle unless input stalls; each byte passes an input
// register and then updates the scan state, and a last byte also loads the result register
// that holds the summary. Input stalls only when a last byte meets a result register that
// is still full. Configuration is read live and is meant to be written between files.
`include "text_buffer_prescan_defines.svh"

module text_buffer_prescan (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_wdata,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // summary output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_has_null,
    output logic        o_likely_utf16,
    output logic        o_likely_utf32,
    output logic        o_cutoff_found,
    output logic [31:0] o_cutoff_index
);

    // configuration
    logic               r_charset;
    tbp_pkg::t_thr      r_text_thr;
    tbp_pkg::t_thr      r_wide_thr;

    // input register
    logic               r_in_valid;
    tbp_pkg::t_byte     r_in_byte;
    logic               r_in_last;

    // scan state
    tbp_pkg::t_peek_arr r_peek,    n_peek;
    tbp_pkg::t_pos      r_pos,     n_pos;
    tbp_pkg::t_len      r_len,     n_len;
    logic               r_null,    n_null;
    logic [1:0]         r_flags,   n_flags;
    logic               r_cut,     n_cut;
    tbp_pkg::t_pos      r_cut_pos, n_cut_pos;
    logic               r_frozen,  n_frozen;

    // result register
    logic               r_out_valid;
    logic               r_out_null;
    logic               r_out_u16;
    logic               r_out_u32;
    logic               r_out_cut;
    logic [31:0]        r_out_idx;

    logic               adv;
    logic               in_peek;
    logic               decide;
    logic [2:0]         peeks;
    logic               peek_null;
    tbp_pkg::t_peek_arr peek_bytes;
    tbp_pkg::t_peek_res peek_res;
    logic               wide_now;
    tbp_pkg::t_thr      thr_now;
    logic               wide_peek;
    tbp_pkg::t_thr      thr_peek;
    tbp_pkg::t_len      len_inc;

    // The held byte moves on unless it is last and the result slot is busy.
    assign adv        = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charset  <= 1'b0;
            r_text_thr <= tbp_pkg::TEXT_THR_RESET;
            r_wide_thr <= tbp_pkg::WIDE_THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tbp_pkg::CFG_CHARSET:  r_charset  <= i_cfg_wdata[0];
                tbp_pkg::CFG_TEXT_THR: r_text_thr <= i_cfg_wdata;
                tbp_pkg::CFG_WIDE_THR: r_wide_thr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // head bytes as they stand with the current byte dropped in
    assign in_peek   = (r_pos[tbp_pkg::INDEX_BITS-1:2] == '0);
    assign peeks     = {1'b0, r_pos[1:0]} + 3'd1;
    assign decide    = in_peek && ((r_pos[1:0] == 2'd3) || r_in_last);
    assign peek_null = r_null || (r_in_byte == tbp_pkg::BYTE_NUL);

    always_comb begin
        peek_bytes = r_peek;
        peek_bytes[r_pos[1:0]] = r_in_byte;
    end

    tbp_peek u_peek (
        .i_bytes            (peek_bytes),
        .i_count            (peeks),
        .i_null_seen        (peek_null),
        .i_charset_enforced (r_charset),
        .o_res              (peek_res)
    );

    // threshold picked from the guess just made (peek) or the stored one
    assign wide_peek = r_charset || peek_res.guess16 || peek_res.guess32;
    assign thr_peek  = wide_peek ? r_wide_thr : r_text_thr;
    assign wide_now  = r_charset || (r_flags != 2'b00);
    assign thr_now   = wide_now ? r_wide_thr : r_text_thr;
    assign len_inc   = (tbp_pkg::is_eol(r_in_byte) ? '0 : r_len) + tbp_pkg::t_len'(1);

    always_comb begin
        n_peek    = r_peek;
        n_pos     = r_pos;
        n_len     = r_len;
        n_null    = r_null;
        n_flags   = r_flags;
        n_cut     = r_cut;
        n_cut_pos = r_cut_pos;
        n_frozen  = r_frozen;

        if (in_peek) begin
            n_peek = peek_bytes;
            n_null = peek_null;
            if (decide) begin
                n_flags = {peek_res.guess32, peek_res.guess16};
                n_len   = peek_res.eol_any ? '0 : tbp_pkg::t_len'(peeks);
                // limit already below the head length
                if (({17'd0, peeks} > thr_peek) && !tbp_pkg::is_eol(peek_bytes[0])) begin
                    n_cut     = 1'b1;
                    n_cut_pos = '0;
                end
            end
        end else begin
            if (!r_frozen && (r_in_byte == tbp_pkg::BYTE_NUL)) begin
                n_null = 1'b1;
            end
            if (!r_cut) begin
                n_len = len_inc;
                if (len_inc > {1'b0, thr_now}) begin
                    n_cut     = 1'b1;
                    n_cut_pos = r_pos - tbp_pkg::t_pos'(wide_now);
                    n_frozen  = 1'b1;
                end
            end
        end

        if (r_pos != '1) begin
            n_pos = r_pos + tbp_pkg::t_pos'(1);
        end
    end

    // scan state: cleared at the end of every file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_in_last)) begin
            r_peek    <= '0;
            r_pos     <= '0;
            r_len     <= '0;
            r_null    <= 1'b0;
            r_flags   <= 2'b00;
            r_cut     <= 1'b0;
            r_cut_pos <= '0;
            r_frozen  <= 1'b0;
        end else if (adv) begin
            r_peek    <= n_peek;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_null    <= n_null;
            r_flags   <= n_flags;
            r_cut     <= n_cut;
            r_cut_pos <= n_cut_pos;
            r_frozen  <= n_frozen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out_null <= n_null;
            r_out_u16  <= n_flags[0];
            r_out_u32  <= n_flags[1];
            r_out_cut  <= n_cut;
            r_out_idx  <= n_cut ? tbp_pkg::OUT_BITS'(n_cut_pos) : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_has_null     = r_out_null;
    assign o_likely_utf16 = r_out_u16;
    assign o_likely_utf32 = r_out_u32;
    assign o_cutoff_found = r_out_cut;
    assign o_cutoff_index = r_out_idx;

    // checks
    `TBP_ASSERT_ALWAYS(a_one_guess, !(r_flags[0] && r_flags[1]))
    `TBP_ASSERT_ALWAYS(a_frozen_needs_cut, !r_frozen || r_cut)
    `TBP_ASSERT_NEXT(a_cut_sticks, r_cut && !(adv && r_in_last), r_cut)
    `TBP_ASSERT_ALWAYS(a_idx_zero_no_cut, !r_out_valid || r_out_cut || (r_out_idx == '0))

endmodule

// ===== dv/tb_text_buffer_prescan.sv =====
`timescale 1ns / 1ps

// Word-level check of text_buffer_prescan: bytes go in one per word, files end
// on a word flagged last, and each summary word is matched against a local model
// of the scan kept in step with every accepted byte, or against a typed directed row.
module tb_text_buffer_prescan;

    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 6;      // pipeline is two deep, plus margin
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 21;
    localparam int PHASES      = 10;
    localparam int PHASE_BYTES = 135;

    // encoding guess flags: bit0 UTF-16, bit1 UTF-32
    localparam logic [1:0] GUESS_NONE = 2'b00;
    localparam logic [1:0] GUESS_U16  = 2'b01;
    localparam logic [1:0] GUESS_U32  = 2'b10;

    localparam tbp_pkg::t_thr THR_MIN = tbp_pkg::t_thr'(4);
    localparam tbp_pkg::t_thr THR_MAX = tbp_pkg::t_thr'(1048575);

    typedef struct packed {
        logic                         has_null;
        logic                         utf16;
        logic                         utf32;
        logic                         cut;
        logic [tbp_pkg::OUT_BITS-1:0] idx;
    } t_summary;

    // one directed byte; the guess fields only count on a typed last byte
    typedef struct packed {
        tbp_pkg::t_byte b;
        logic           lst;
        logic           typed;
        logic           nul;
        logic           u16;
        logic           u32;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // FF FE mark with a NUL: UTF-16
        '{tbp_pkg::BYTE_FF,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_FE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h41,             1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_NUL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        // FE FF mark with a NUL: UTF-16
        '{tbp_pkg::BYTE_FE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_FF,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_NUL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h41,             1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        // alternating NULs: UTF-16
        '{8'h41,             1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_NUL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h42,             1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_NUL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        // NN NN 00 00: UTF-32
        '{8'h41,             1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h42,             1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_NUL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_NUL, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
        // two-byte file, exactly one NUL: UTF-16
        '{8'h41,             1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_NUL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        // two-byte file, both NUL: no guess
        '{tbp_pkg::BYTE_NUL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_NUL, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        // one-byte file of all ones
        '{tbp_pkg::BYTE_FF,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        // byte-order mark but no NUL: no guess
        '{tbp_pkg::BYTE_FF,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{tbp_pkg::BYTE_FE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h41,             1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h42,             1'b1, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = 2'b00;
    logic [19:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_has_null;
    logic        o_likely_utf16;
    logic        o_likely_utf32;
    logic        o_cutoff_found;
    logic [31:0] o_cutoff_index;

    text_buffer_prescan dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_has_null     (o_has_null),
        .o_likely_utf16 (o_likely_utf16),
        .o_likely_utf32 (o_likely_utf32),
        .o_cutoff_found (o_cutoff_found),
        .o_cutoff_index (o_cutoff_index)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Local copy of the register file and of the scan state
    // ---------------------------------------------------------------
    logic           cfg_enforce  = 1'b0;
    tbp_pkg::t_thr  cfg_text_thr = tbp_pkg::TEXT_THR_RESET;
    tbp_pkg::t_thr  cfg_wide_thr = tbp_pkg::WIDE_THR_RESET;

    tbp_pkg::t_byte peek_hold [tbp_pkg::PEEK_BYTES] = '{default: tbp_pkg::BYTE_NUL};
    tbp_pkg::t_pos  scan_pos   = '0;
    tbp_pkg::t_len  line_run   = '0;
    logic           nul_seen   = 1'b0;
    logic           nul_frozen = 1'b0;
    logic [1:0]     enc_guess  = GUESS_NONE;
    logic           cut_done   = 1'b0;
    tbp_pkg::t_pos  cut_at     = '0;

    t_summary summary_q [$];

    // side channel that travels with the payload: typed directed expectation
    logic     cur_typed = 1'b0;
    t_summary cur_want  = '0;

    // shared control, set by the stimulus with NBAs
    logic calm       = 1'b0;   // no idling on either side
    logic hold_start = 1'b0;   // receiver starts its long hold-off

    int unsigned fails       = 0;
    int unsigned bytes_in    = 0;
    int unsigned words_out   = 0;
    int unsigned cuts_seen   = 0;
    int unsigned settings    = 1;
    int unsigned cycles      = 0;

    function automatic logic line_break(input tbp_pkg::t_byte b);
        return (b == tbp_pkg::BYTE_LF) || (b == tbp_pkg::BYTE_CR);
    endfunction

    // Advances the scan by one byte; returns 1 with the summary on a last byte.
    function automatic bit prescan_byte(input tbp_pkg::t_byte b, input logic lst,
                                        output t_summary s);
        int unsigned   held;
        int unsigned   k;
        tbp_pkg::t_len run;
        tbp_pkg::t_thr lim;
        logic          wide;
        logic          bom;
        logic          p16;
        logic          p32;
        logic          nz [tbp_pkg::PEEK_BYTES];
        s = '0;
        if (scan_pos < tbp_pkg::PEEK_BYTES) begin
            peek_hold[scan_pos[1:0]] = b;
            if (b == tbp_pkg::BYTE_NUL)
                nul_seen = 1'b1;
            // peek decision on the fourth byte or the end of a shorter file
            if (scan_pos == tbp_pkg::PEEK_BYTES - 1 || lst) begin
                held = scan_pos + 1;
                for (k = 0; k < tbp_pkg::PEEK_BYTES; k++)
                    nz[k] = (peek_hold[k] != tbp_pkg::BYTE_NUL);
                if (!cfg_enforce) begin
                    if (held == 2 && (nz[0] != nz[1]))
                        enc_guess = GUESS_U16;
                    if (held == 4 && nul_seen) begin
                        bom = (peek_hold[0] == tbp_pkg::BYTE_FF &&
                               peek_hold[1] == tbp_pkg::BYTE_FE) ||
                              (peek_hold[0] == tbp_pkg::BYTE_FE &&
                               peek_hold[1] == tbp_pkg::BYTE_FF);
                        p16 = (nz[0] && !nz[1] && nz[2] && !nz[3]) ||
                              (!nz[0] && nz[1] && !nz[2] && nz[3]);
                        p32 = (nz[0] && nz[1] && !nz[2] && !nz[3]) ||
                              (!nz[0] && !nz[1] && nz[2] && nz[3]);
                        if (bom || p16)
                            enc_guess = GUESS_U16;
                        else if (p32)
                            enc_guess = GUESS_U32;
                    end
                end
                run = tbp_pkg::t_len'(held);
                for (k = 0; k < held; k++)
                    if (line_break(peek_hold[k]))
                        run = '0;
                lim = (cfg_enforce || enc_guess != GUESS_NONE) ? cfg_wide_thr : cfg_text_thr;
                if (held > lim && !line_break(peek_hold[0])) begin
                    cut_done = 1'b1;
                    cut_at   = '0;
                end
                line_run = run;
            end
        end else begin
            if (!nul_frozen && b == tbp_pkg::BYTE_NUL)
                nul_seen = 1'b1;
            if (!cut_done) begin
                if (line_break(b))
                    line_run = '0;
                line_run = line_run + 1'b1;
                wide = cfg_enforce || (enc_guess != GUESS_NONE);
                lim  = wide ? cfg_wide_thr : cfg_text_thr;
                if (line_run > {1'b0, lim}) begin
                    cut_done   = 1'b1;
                    cut_at     = scan_pos - (wide ? 1 : 0);
                    nul_frozen = 1'b1;
                end
            end
        end
        if (scan_pos != '1)
            scan_pos = scan_pos + 1'b1;
        if (!lst)
            return 1'b0;
        s.has_null = nul_seen;
        s.utf16    = enc_guess[0];
        s.utf32    = enc_guess[1];
        s.cut      = cut_done;
        s.idx      = cut_done ? cut_at[tbp_pkg::OUT_BITS-1:0] : '0;
        // file closed: scan state back to reset, registers kept
        peek_hold  = '{default: tbp_pkg::BYTE_NUL};
        scan_pos   = '0;
        line_run   = '0;
        nul_seen   = 1'b0;
        nul_frozen = 1'b0;
        enc_guess  = GUESS_NONE;
        cut_done   = 1'b0;
        cut_at     = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Monitor: output words checked first, then the accepted input byte
    // is folded into the model (latency keeps the two apart).
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_summary got;
        t_summary want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_has_null, o_likely_utf16, o_likely_utf32,
                        o_cutoff_found, o_cutoff_index};
                if (summary_q.size() == 0) begin
                    $error("summary word with nothing expected");
                    fails++;
                end else begin
                    want = summary_q.pop_front();
                    words_out++;
                    if (got.cut)
                        cuts_seen++;
                    if (got.has_null !== want.has_null) begin
                        $error("has_null: expected %0d, got %0d", want.has_null, got.has_null);
                        fails++;
                    end
                    if (got.utf16 !== want.utf16) begin
                        $error("likely_utf16: expected %0d, got %0d", want.utf16, got.utf16);
                        fails++;
                    end
                    if (got.utf32 !== want.utf32) begin
                        $error("likely_utf32: expected %0d, got %0d", want.utf32, got.utf32);
                        fails++;
                    end
                    if (got.cut !== want.cut) begin
                        $error("cutoff_found: expected %0d, got %0d", want.cut, got.cut);
                        fails++;
                    end
                    if (got.idx !== want.idx) begin
                        $error("cutoff_index: expected %0d, got %0d", want.idx, got.idx);
                        fails++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                bytes_in++;
                // model always advances; typed directed rows override its answer
                if (prescan_byte(i_data_byte, i_last_byte, want))
                    summary_q.push_back(cur_typed ? cur_want : want);
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off on request
    // ---------------------------------------------------------------
    int unsigned hold_left = 0;
    logic        hold_used = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_start && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("text_buffer_prescan verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // byte mix weighted toward NUL, line breaks and mark bytes
    function automatic tbp_pkg::t_byte rnd_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return tbp_pkg::BYTE_NUL;
        else if (r < 18)
            return tbp_pkg::BYTE_LF;
        else if (r < 22)
            return tbp_pkg::BYTE_CR;
        else if (r < 26)
            return tbp_pkg::BYTE_FF;
        else if (r < 30)
            return tbp_pkg::BYTE_FE;
        return tbp_pkg::t_byte'($urandom_range(0, 255));
    endfunction

    function automatic tbp_pkg::t_byte rnd_nonzero();
        return tbp_pkg::t_byte'($urandom_range(1, 255));
    endfunction

    // Offers one word and holds it until taken; each cycle before it may idle.
    task automatic send_byte(input tbp_pkg::t_byte b, input logic lst, input logic typed,
                             input t_summary want);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        cur_typed   <= typed;
        cur_want    <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // One file; the head is shaped so the peek logic sees marks and NUL patterns.
    task automatic send_file(input int unsigned len);
        tbp_pkg::t_byte head [tbp_pkg::PEEK_BYTES];
        int unsigned    kind;
        int unsigned    k;
        for (k = 0; k < tbp_pkg::PEEK_BYTES; k++)
            head[k] = rnd_byte();
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                head[0] = tbp_pkg::BYTE_FF;
                head[1] = tbp_pkg::BYTE_FE;
                if ($urandom_range(0, 1)) head[3] = tbp_pkg::BYTE_NUL;
            end
            1: begin
                head[0] = tbp_pkg::BYTE_FE;
                head[1] = tbp_pkg::BYTE_FF;
                if ($urandom_range(0, 1)) head[2] = tbp_pkg::BYTE_NUL;
            end
            2: head = '{rnd_nonzero(), tbp_pkg::BYTE_NUL, rnd_nonzero(), tbp_pkg::BYTE_NUL};
            3: head = '{tbp_pkg::BYTE_NUL, rnd_nonzero(), tbp_pkg::BYTE_NUL, rnd_nonzero()};
            4: head = '{rnd_nonzero(), rnd_nonzero(), tbp_pkg::BYTE_NUL, tbp_pkg::BYTE_NUL};
            5: head = '{tbp_pkg::BYTE_NUL, tbp_pkg::BYTE_NUL, rnd_nonzero(), rnd_nonzero()};
            6: begin
                // two-byte file with one NUL
                len = 2;
                head[0] = $urandom_range(0, 1) ? tbp_pkg::BYTE_NUL : rnd_nonzero();
                head[1] = (head[0] == tbp_pkg::BYTE_NUL) ? rnd_nonzero() : tbp_pkg::BYTE_NUL;
            end
            default: ;
        endcase
        for (k = 0; k < len; k++)
            send_byte((k < tbp_pkg::PEEK_BYTES) ? head[k] : rnd_byte(), (k == len - 1),
                      1'b0, '0);
    endtask

    // Register writes only with the block drained.
    task automatic program_regs(input logic enf, input tbp_pkg::t_thr txt,
                                input tbp_pkg::t_thr wth);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (summary_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= tbp_pkg::CFG_CHARSET;
        i_cfg_wdata <= 20'(enf);
        @(posedge i_clk);
        i_cfg_idx   <= tbp_pkg::CFG_TEXT_THR;
        i_cfg_wdata <= txt;
        @(posedge i_clk);
        i_cfg_idx   <= tbp_pkg::CFG_WIDE_THR;
        i_cfg_wdata <= wth;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_enforce  = enf;
        cfg_text_thr = txt;
        cfg_wide_thr = wth;
        settings++;
    endtask

    function automatic tbp_pkg::t_thr rnd_thr();
        // mostly short limits so cutoffs are frequent
        if ($urandom_range(0, 99) < 80)
            return tbp_pkg::t_thr'($urandom_range(4, 24));
        return tbp_pkg::t_thr'($urandom_range(THR_MIN, THR_MAX));
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int unsigned   r;
        int unsigned   ph;
        int unsigned   len;
        int unsigned   sent;
        int unsigned   k;
        logic          enf;
        tbp_pkg::t_thr txt;
        tbp_pkg::t_thr wth;
        t_summary      want;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed files at the reset register values
        for (r = 0; r < DIR_ROWS; r++) begin
            want = '{DIRECTED[r].nul, DIRECTED[r].u16, DIRECTED[r].u32, 1'b0, '0};
            send_byte(DIRECTED[r].b, DIRECTED[r].lst, DIRECTED[r].typed, want);
        end

        // random files over a series of register settings
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin enf = 1'b0; txt = THR_MIN; wth = THR_MIN; end
                1: begin enf = 1'b1; txt = THR_MAX; wth = THR_MIN; end
                2: begin enf = 1'b0; txt = THR_MAX; wth = THR_MAX; end
                3: begin enf = 1'b1; txt = THR_MIN; wth = THR_MAX; end
                default: begin
                    enf = $urandom_range(0, 1);
                    txt = rnd_thr();
                    wth = rnd_thr();
                end
            endcase
            program_regs(enf, txt, wth);
            calm <= (ph == 2);

            // receiver holds off while one-byte files pile into the block
            if (ph == 5) begin
                hold_start <= 1'b1;
                for (k = 0; k < 40; k++)
                    send_file(1);
            end

            sent = 0;
            while (sent < PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = $urandom_range(1, 3);
                else if (r < 90)
                    len = $urandom_range(4, 20);
                else
                    len = $urandom_range(21, 60);
                send_file(len);
                sent += len;
            end
        end

        // drain, then wait quietly to catch stray words
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (summary_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE * 2) @(posedge i_clk);

        $display("run: %0d bytes over %0d register settings, %0d summary words checked",
                 bytes_in, settings, words_out);
        $display("     %0d summaries reported a line cutoff", cuts_seen);
        if (fails == 0)
            $display("text_buffer_prescan verification clean");
        else
            $display("text_buffer_prescan verification failed");
        $finish;
    end

endmodule
